>>> sv/hca_pkg.sv
// Shared types and constants for the HLS color adjuster.
// No dependencies; imported by hca_front, hca_back and the top level.
package hca_pkg;

   // restoring divider: quotient and remainder widths
   localparam int QUOT_W = 9;
   localparam int REM_W  = 21;

   // hue angles in units of 1/255 degree
   localparam int SEG_W    = 15300;   // 60 degrees
   localparam int THIRD    = 30600;   // 120 degrees
   localparam int HALF     = 45900;   // 180 degrees
   localparam int SEG2_END = 61200;   // 240 degrees
   localparam int TURN     = 91800;   // 360 degrees

   // back conversion divisor 255 * 60 * 255 and its reciprocal
   localparam longint unsigned DIV_D   = 64'd3901500;
   localparam int              RECIP_K = 52;
   localparam longint unsigned RECIP_M = (64'd1 << RECIP_K) / DIV_D;

   // word handed from the front end to the back end
   typedef struct packed {
      logic [REM_W-1:0]   num_s;
      logic [8:0]         den_s;
      logic [REM_W-1:0]   num_h;
      logic [11:0]        den_h;
      logic [7:0]         light;
      logic [7:0]         hue_shift;
      logic signed [8:0]  light_shift;
      logic signed [8:0]  sat_shift;
   } work_type;

endpackage

>>> sv/hca_fifo.sv
// Small synchronous queue built from registers.
// Standalone; used between front and back end and on the result side.
module hca_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/hca_front.sv
// Front end: takes a color, finds max/min and sets up the divisions
// for saturation and hue. Uses hca_pkg.
module hca_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [23:0]       req_color_in,
   input  logic [7:0]        req_hue_shift,
   input  logic signed [8:0] req_light_shift,
   input  logic signed [8:0] req_sat_shift,
   output logic              mid_push,
   output hca_pkg::work_type mid_data,
   input  logic              mid_full
);
   import hca_pkg::*;

   logic             valid_ff;
   work_type         work_ff, work_in;
   logic             advance;
   logic [7:0]       r, g, b, mx, mn, d, lt;
   logic [8:0]       sum, den;
   logic [11:0]      d6;
   logic signed [11:0] hn;
   logic [10:0]      hn_u;

   assign advance  = !valid_ff || !mid_full;
   assign req_full = !advance;
   assign mid_push = valid_ff && !mid_full;
   assign mid_data = work_ff;

   always_comb begin
      r   = req_color_in[7:0];
      g   = req_color_in[15:8];
      b   = req_color_in[23:16];
      mx  = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn  = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = {1'b0, mx} + {1'b0, mn};
      d   = mx - mn;
      lt  = 8'((10'(sum) + 10'd1) >> 1);
      den = (sum <= 9'd255) ? sum : 9'(10'd510 - 10'(sum));
      d6  = 12'(d) * 12'd6;
      if (r == mx) begin
         hn = $signed({4'b0, g}) - $signed({4'b0, b});
      end else if (g == mx) begin
         hn = $signed(12'(d) << 1) + $signed({4'b0, b}) - $signed({4'b0, r});
      end else begin
         hn = $signed(12'(d) << 2) + $signed({4'b0, r}) - $signed({4'b0, g});
      end
      if (hn < 0) hn = hn + $signed(d6);
      hn_u = 11'(hn);

      work_in.light       = lt;
      work_in.hue_shift   = req_hue_shift;
      work_in.light_shift = req_light_shift;
      work_in.sat_shift   = req_sat_shift;
      if (d == 8'd0) begin
         // grey: both quotients come out zero
         work_in.num_s = '0;
         work_in.den_s = 9'd1;
         work_in.num_h = '0;
         work_in.den_h = 12'd1;
      end else begin
         work_in.num_s = REM_W'(d) * REM_W'(510) + REM_W'(den);
         work_in.den_s = {den[7:0], 1'b0};
         work_in.num_h = REM_W'(hn_u) * REM_W'(510) + REM_W'(d6);
         work_in.den_h = 12'(d) * 12'd12;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_push;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_push) begin
         work_ff <= work_in;
      end
   end

endmodule

>>> sv/hca_back.sv
// Back end: pipelined dividers, offset/clamp, and the back conversion
// to RGB with a reciprocal divide. Uses hca_pkg.
module hca_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              mid_empty,
   input  hca_pkg::work_type mid_head,
   output logic              mid_pop,
   input  logic              out_full,
   output logic              out_push,
   output logic [23:0]       out_data
);
   import hca_pkg::*;

   localparam int NDIV = QUOT_W;

   logic advance;

   // divider stages
   logic                   dv_ff   [NDIV];
   logic [REM_W-1:0]       rs_ff   [NDIV];
   logic [REM_W-1:0]       rh_ff   [NDIV];
   logic [QUOT_W-1:0]      qs_ff   [NDIV];
   logic [QUOT_W-1:0]      qh_ff   [NDIV];
   work_type               wk_ff   [NDIV];

   // later stages
   logic        va_ff, vm1_ff, vm2_ff, vm3_ff, vr1_ff, vr2_ff;
   logic [7:0]  ha_ff, la_ff, sa_ff, ha_in, la_in, sa_in;
   logic [7:0]  lm_ff, sm_ff;
   logic [15:0] p_ff;
   logic [16:0] hu_ff;
   logic [15:0] n1_ff, dn_ff;
   logic [13:0] w_ff   [3];
   logic [29:0] num_ff [3];
   logic [29:0] numr_ff[3];
   logic [60:0] prod_ff[3];
   logic [29:0] num2_ff[3];
   logic [8:0]  q0_ff  [3];
   logic [30:0] qd_ff  [3];

   assign advance  = !out_full;
   assign mid_pop  = advance && !mid_empty;
   assign out_push = advance && vr2_ff;

   // ---------------- divider, one quotient bit per stage ----------------
   for (genvar k = 0; k < NDIV; k++) begin : g_div
      logic [REM_W-1:0]  rs_prev, rh_prev, ts, th;
      logic [QUOT_W-1:0] qs_prev, qh_prev;
      work_type          wk_prev;
      logic              v_prev;
      logic [REM_W-1:0]  rs_in, rh_in;
      logic [QUOT_W-1:0] qs_in, qh_in;

      if (k == 0) begin : g_first
         assign v_prev  = !mid_empty;
         assign wk_prev = mid_head;
         assign rs_prev = mid_head.num_s;
         assign rh_prev = mid_head.num_h;
         assign qs_prev = '0;
         assign qh_prev = '0;
      end else begin : g_rest
         assign v_prev  = dv_ff[k-1];
         assign wk_prev = wk_ff[k-1];
         assign rs_prev = rs_ff[k-1];
         assign rh_prev = rh_ff[k-1];
         assign qs_prev = qs_ff[k-1];
         assign qh_prev = qh_ff[k-1];
      end

      always_comb begin
         ts = REM_W'(wk_prev.den_s) << (NDIV-1-k);
         th = REM_W'(wk_prev.den_h) << (NDIV-1-k);
         if (rs_prev >= ts) begin
            rs_in = rs_prev - ts;
            qs_in = {qs_prev[QUOT_W-2:0], 1'b1};
         end else begin
            rs_in = rs_prev;
            qs_in = {qs_prev[QUOT_W-2:0], 1'b0};
         end
         if (rh_prev >= th) begin
            rh_in = rh_prev - th;
            qh_in = {qh_prev[QUOT_W-2:0], 1'b1};
         end else begin
            rh_in = rh_prev;
            qh_in = {qh_prev[QUOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            wk_ff[k] <= wk_prev;
            rs_ff[k] <= rs_in;
            rh_ff[k] <= rh_in;
            qs_ff[k] <= qs_in;
            qh_ff[k] <= qh_in;
         end
      end
   end

   // ---------------- offsets, hue wrap, clamps ----------------
   always_comb begin
      logic [9:0]         hsum;
      logic signed [10:0] lsum, ssum;
      hsum = 10'(qh_ff[NDIV-1]) + 10'(wk_ff[NDIV-1].hue_shift);
      lsum = $signed({3'b0, wk_ff[NDIV-1].light}) + 11'(wk_ff[NDIV-1].light_shift);
      ssum = $signed({2'b0, qs_ff[NDIV-1]}) + 11'(wk_ff[NDIV-1].sat_shift);
      if (hsum >= 10'd510) begin
         ha_in = 8'd0;
      end else if (hsum > 10'd255) begin
         ha_in = 8'(hsum - 10'd255);
      end else begin
         ha_in = 8'(hsum);
      end
      if (lsum < 0) la_in = 8'd0;
      else if (lsum > 255) la_in = 8'd255;
      else la_in = 8'(lsum);
      if (ssum < 0) sa_in = 8'd0;
      else if (ssum > 255) sa_in = 8'd255;
      else sa_in = 8'(ssum);
   end

   // ---------------- m1/m2 and hue segments ----------------
   logic [15:0] n1_in, dn_in;
   logic [13:0] w_in [3];

   always_comb begin
      logic [17:0]        l255, s255, n2;
      logic signed [18:0] hx;
      l255 = (18'(lm_ff) << 8) - 18'(lm_ff);
      s255 = (18'(sm_ff) << 8) - 18'(sm_ff);
      if (lm_ff < 8'd128) begin
         n2 = l255 + 18'(p_ff);
      end else begin
         n2 = l255 + s255 - 18'(p_ff);
      end
      n1_in = 16'((l255 << 1) - n2);
      dn_in = 16'(n2 - ((l255 << 1) - n2));
      for (int c = 0; c < 3; c++) begin
         // red leads by 120 degrees, blue lags by 120
         hx = $signed({2'b0, hu_ff});
         if (c == 0) hx = hx + 19'sd30600;
         if (c == 2) hx = hx - 19'sd30600;
         if (hx < 0) hx = hx + 19'sd91800;
         if (hx > 19'sd91800) hx = hx - 19'sd91800;
         if (hx < 19'(SEG_W)) begin
            w_in[c] = 14'(hx);
         end else if (hx < 19'(HALF)) begin
            w_in[c] = 14'(SEG_W);
         end else if (hx < 19'(SEG2_END)) begin
            w_in[c] = 14'(19'(SEG2_END) - hx);
         end else begin
            w_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vm1_ff <= 1'b0;
         vm2_ff <= 1'b0;
         vm3_ff <= 1'b0;
         vr1_ff <= 1'b0;
         vr2_ff <= 1'b0;
      end else if (advance) begin
         va_ff  <= dv_ff[NDIV-1];
         vm1_ff <= va_ff;
         vm2_ff <= vm1_ff;
         vm3_ff <= vm2_ff;
         vr1_ff <= vm3_ff;
         vr2_ff <= vr1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ha_ff <= ha_in;
         la_ff <= la_in;
         sa_ff <= sa_in;
         lm_ff <= la_ff;
         sm_ff <= sa_ff;
         p_ff  <= 16'(la_ff) * 16'(sa_ff);
         hu_ff <= 17'(ha_ff) * 17'd360;
         n1_ff <= n1_in;
         dn_ff <= dn_in;
         for (int c = 0; c < 3; c++) begin
            w_ff[c]    <= w_in[c];
            num_ff[c]  <= 30'(n1_ff) * 30'(SEG_W) + 30'(dn_ff) * 30'(w_ff[c]);
            numr_ff[c] <= num_ff[c];
            prod_ff[c] <= 61'(num_ff[c]) * 61'(RECIP_M);
            num2_ff[c] <= numr_ff[c];
            q0_ff[c]   <= 9'(prod_ff[c] >> RECIP_K);
            qd_ff[c]   <= 31'(9'(prod_ff[c] >> RECIP_K)) * 31'(DIV_D);
         end
      end
   end

   // quotient estimate is low by at most one
   always_comb begin
      logic [8:0] q;
      for (int c = 0; c < 3; c++) begin
         if (31'(num2_ff[c]) - qd_ff[c] >= 31'(DIV_D)) begin
            q = q0_ff[c] + 9'd1;
         end else begin
            q = q0_ff[c];
         end
         out_data[c*8 +: 8] = (q > 9'd255) ? 8'd255 : 8'(q);
      end
   end

endmodule

>>> sv/hls_color_adjust_top.sv
// HLS color adjuster, top level. Uses hca_pkg, hca_front, hca_back
// and hca_fifo.
//
// Input channel (req_*): push a packed RGB word (red 7:0, green 15:8,
// blue 23:16) with a hue offset and signed lightness and saturation
// offsets; the word is taken on a clock edge with req_push high and
// req_full low. Result channel (rsp_*): the adjusted color is on
// rsp_color_out while rsp_empty is low and leaves on an edge with
// rsp_pop high. Every input word gives exactly one result, in order.
// Throughput: one word per cycle while the result queue is not full.
// Path from the accepting edge to rsp_empty falling, with empty queues:
// the front stage loads on that edge, then the middle queue, nine
// restoring-divider stages (one quotient bit each for saturation and
// hue), six adjust/back-conversion stages, and the result queue. When the
// receiver stalls the back pipeline holds, the middle queue fills, and
// then req_full rises; no word is lost.
// Reset clears all valid flags and queue pointers and counts; nothing else.
module hls_color_adjust_top #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [23:0]       req_color_in,
   input  logic [7:0]        req_hue_shift,
   input  logic signed [8:0] req_light_shift,
   input  logic signed [8:0] req_sat_shift,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [23:0]       rsp_color_out
);
   import hca_pkg::*;

   logic     mid_push, mid_full, mid_pop, mid_empty;
   work_type mid_data, mid_head;
   logic     out_push, out_full;
   logic [23:0] out_data;

   hca_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_color_in    (req_color_in),
      .req_hue_shift   (req_hue_shift),
      .req_light_shift (req_light_shift),
      .req_sat_shift   (req_sat_shift),
      .mid_push        (mid_push),
      .mid_data        (mid_data),
      .mid_full        (mid_full)
   );

   hca_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .head      (mid_head)
   );

   hca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_head  (mid_head),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   hca_fifo #(
      .WIDTH (24),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_color_out)
   );

endmodule

>>> verif/tb.sv
// Testbench for hls_color_adjust_top: random and directed RGB words with HLS offsets.
// Depends on the RTL only; predicts each adjusted color in integer arithmetic.
module tb;

   class color_scoreboard;
      logic [23:0] pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      static function int clip8(int v);
         if (v < 0) return 0;
         if (v > 255) return 255;
         return v;
      endfunction

      static function int channel(longint n1, longint n2, longint hu);
         longint num;
         longint r;
         if (hu < 0) hu += 91800;
         if (hu > 91800) hu -= 91800;
         if (hu < 15300) begin
            num = n1 * 15300 + (n2 - n1) * hu;
            r = num / 3901500;
         end else if (hu < 45900) begin
            r = n2 / 255;
         end else if (hu < 61200) begin
            num = n1 * 15300 + (n2 - n1) * (61200 - hu);
            r = num / 3901500;
         end else begin
            r = n1 / 255;
         end
         if (r < 0) r = 0;
         if (r > 255) r = 255;
         return int'(r);
      endfunction

      static function logic [23:0] adjust(logic [23:0] c, logic [7:0] hs,
                                          logic signed [8:0] ls, logic signed [8:0] ss);
         int rd, gr, bl, mx, mn, sm, d, h, l, s, den, hn;
         longint n1, n2, hu;
         int ro, go, bo;
         rd = c[7:0]; gr = c[15:8]; bl = c[23:16];
         mx = rd; if (gr > mx) mx = gr; if (bl > mx) mx = bl;
         mn = rd; if (gr < mn) mn = gr; if (bl < mn) mn = bl;
         sm = mx + mn;
         d = mx - mn;
         l = (sm + 1) / 2;
         if (d == 0) begin
            h = 0; s = 0;
         end else begin
            den = (sm <= 255) ? sm : 510 - sm;
            s = (510 * d + den) / (2 * den);
            if (rd == mx) hn = gr - bl;
            else if (gr == mx) hn = 2 * d + bl - rd;
            else hn = 4 * d + rd - gr;
            if (hn < 0) hn += 6 * d;
            h = (510 * hn + 6 * d) / (12 * d);
         end
         h += hs;
         l = clip8(l + int'(ls));
         s = clip8(s + int'(ss));
         if (h > 255) h = h % 255;
         if (s == 0) begin
            ro = l; go = l; bo = l;
         end else begin
            if (2 * l < 255) n2 = longint'(l) * (255 + s);
            else n2 = 255 * l + 255 * s - longint'(l) * s;
            n1 = 510 * l - n2;
            hu = longint'(h) * 360;
            ro = channel(n1, n2, hu + 30600);
            go = channel(n1, n2, hu);
            bo = channel(n1, n2, hu - 30600);
         end
         return {bo[7:0], go[7:0], ro[7:0]};
      endfunction

      function void note_word(logic [23:0] c, logic [7:0] hs,
                              logic signed [8:0] ls, logic signed [8:0] ss);
         pending.push_back(adjust(c, hs, ls, ss));
      endfunction

      function void check_color(logic [23:0] got);
         logic [23:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected color %06h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: color_out expected %06h actual %06h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_push = 0, rsp_pop = 0;
   logic req_full, rsp_empty;
   logic [23:0] req_color_in = 0, rsp_color_out;
   logic [7:0] req_hue_shift = 0;
   logic signed [8:0] req_light_shift = 0, req_sat_shift = 0;

   color_scoreboard sb = new();
   int push_idle, pop_idle;
   bit rx_hold;
   int quiet;

   hls_color_adjust_top u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random pop, checks at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_color(rsp_color_out);
   end
   always @(negedge clock) begin
      rsp_pop <= !reset && !rx_hold && ($urandom_range(99) >= pop_idle);
   end

   // watchdog on accepted words and popped results
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 5000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic send_word(logic [23:0] c, logic [7:0] hs,
                            logic signed [8:0] ls, logic signed [8:0] ss);
      while ($urandom_range(99) < push_idle) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_color_in <= c;
      req_hue_shift <= hs;
      req_light_shift <= ls;
      req_sat_shift <= ss;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_word(c, hs, ls, ss);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [23:0] c;
      logic signed [8:0] ls, ss;
      c = 24'($urandom);
      if ($urandom_range(9) == 0) c = {3{c[7:0]}};
      ls = 9'($urandom);
      ss = 9'($urandom);
      if ($urandom_range(3) == 0) ls = 9'(int'($urandom_range(60)) - 30);
      if ($urandom_range(3) == 0) ss = 9'(int'($urandom_range(60)) - 30);
      send_word(c, 8'($urandom), ls, ss);
   endtask

   task automatic drain();
      req_push <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      rx_hold = 0;
      push_idle = 0;
      pop_idle = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, greys, each sector, wrap, clamps, -256
      send_word(24'h000000, 0, 0, 0);
      send_word(24'hFFFFFF, 0, 0, 0);
      send_word(24'h808080, 8'd40, 9'sd0, 9'sd100);
      send_word(24'h0000FF, 0, 0, 0);
      send_word(24'h00FF00, 0, 0, 0);
      send_word(24'hFF0000, 0, 0, 0);
      send_word(24'h00FFFF, 0, 0, 0);
      send_word(24'hFF00FF, 0, 0, 0);
      send_word(24'hFFFF00, 0, 0, 0);
      send_word(24'h0000FF, 8'd255, 0, 0);
      send_word(24'h2040C0, 8'd200, 0, 0);
      send_word(24'h2040C0, 8'd255, 9'sd255, 9'sd255);
      send_word(24'h2040C0, 8'd128, -9'sd255, -9'sd255);
      send_word(24'h123456, 0, 9'h100, 9'h100);
      send_word(24'h123456, 8'd1, 9'sd0, 9'h100);
      send_word(24'hC08040, 8'd85, 9'sd60, 9'sd0);
      send_word(24'h80FF7F, 8'd170, -9'sd60, 9'sd10);
      send_word(24'h010000, 0, 0, 0);
      send_word(24'hFEFFFF, 0, 0, 0);
      drain();

      // receiver stalls while the sender keeps pushing
      rx_hold = 1;
      fork
         begin repeat (300) @(negedge clock); rx_hold = 0; end
         repeat (40) send_random();
      join
      drain();

      push_idle = 15; pop_idle = 81;
      repeat (400) send_random();
      drain();
      push_idle = 81; pop_idle = 15;
      repeat (400) send_random();
      drain();
      push_idle = 0; pop_idle = 0;
      repeat (460) send_random();
      drain();

      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
